@@ rtl/ple_pkg.sv @@
// Shared types and codes for the positional list engine.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned GROUP        = 8;
  localparam int unsigned GROUP_W      = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_POS   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic [7:0]              position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [7:0]              match_position;
    logic signed [VAL_W-1:0] read_value;
    logic [7:0]              list_length;
  } out_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic find;
    logic rd;
  } cell_ctrl_t;

endpackage

@@ rtl/ple_cell.sv @@
// One list entry: shifts with its neighbors on insert/delete, flags a hit.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 7,
  parameter int unsigned CW  = 8
) (
  input  logic                             clk_i,
  input  ple_pkg::cell_ctrl_t              ctrl_i,
  input  logic [IW-1:0]                    idx_i,
  input  logic [CW-1:0]                    cnt_i,
  input  logic signed [ple_pkg::VAL_W-1:0] value_i,
  input  logic signed [ple_pkg::VAL_W-1:0] prev_i,
  input  logic signed [ple_pkg::VAL_W-1:0] next_i,
  output logic signed [ple_pkg::VAL_W-1:0] ent_o,
  output logic                             hit_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic signed [ple_pkg::VAL_W-1:0] ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      if (MY_IDX == idx_i) begin
        ent_d = value_i;
      end else if (MY_IDX > idx_i) begin
        ent_d = prev_i;
      end
    end else if (ctrl_i.del) begin
      if (MY_IDX >= idx_i) begin
        ent_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign hit_o = (ctrl_i.rd && (MY_IDX == idx_i)) ||
                 (ctrl_i.find && (MY_CNT < cnt_i) && (ent_q == value_i));

endmodule

@@ rtl/ple_group.sv @@
// First-hit select over one group of cells, registered.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_group (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic [ple_pkg::GROUP-1:0]                    hit_i,
  input  logic [ple_pkg::GROUP-1:0][ple_pkg::VAL_W-1:0] val_i,
  output logic                                         any_o,
  output logic [ple_pkg::GROUP_W-1:0]                  loc_o,
  output logic [ple_pkg::VAL_W-1:0]                    val_o
);

  logic                        any_q, any_d;
  logic [ple_pkg::GROUP_W-1:0] loc_q, loc_d;
  logic [ple_pkg::VAL_W-1:0]   val_q, val_d;

  always_comb begin
    any_d = 1'b0;
    loc_d = '0;
    val_d = '0;
    for (int i = ple_pkg::GROUP - 1; i >= 0; i--) begin
      if (hit_i[i]) begin
        any_d = 1'b1;
        loc_d = ple_pkg::GROUP_W'(i);
        val_d = val_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      any_q <= any_d;
      loc_q <= loc_d;
      val_q <= val_d;
    end
  end

  assign any_o = any_q;
  assign loc_o = loc_q;
  assign val_o = val_q;

endmodule

@@ rtl/positional_list_engine_top.sv @@
// Top level of the positional list engine: cell row, group selects, control.
// Depends on ple_pkg, ple_cell and ple_group.
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values, one entry per cell in a row of
// CAPACITY cells. Insert and delete shift the whole row in the cycle the
// request beat is taken; find and read flag hits in every cell at once.
// The result beat passes through the registered hit flags and the registered
// first-hit select within groups of eight cells before it reaches the output
// register; the select across groups feeds the output register directly. One
// request is in the selection path at a time, so a new request is taken only
// after the previous one has left that path; the next request can be taken while
// the previous result still waits in the output register.
// Entries need no clearing after reset: only positions below the length
// are ever read or compared.
module positional_list_engine_top #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ple_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ple_pkg::out_t out_data_o
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned WW  = CW + 8;
  localparam int unsigned G   = ple_pkg::GROUP;
  localparam int unsigned GW  = ple_pkg::GROUP_W;
  localparam int unsigned NG  = (CAPACITY + G - 1) / G;
  localparam int unsigned NGW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned MW  = NGW + GW + 8;

  logic acc;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [WW-1:0] pos_w, cnt_w;
  logic [IW-1:0] idx;
  logic full, ins_ok, pos_ok;
  ple_pkg::cell_ctrl_t ctrl;

  logic [CAPACITY-1:0][ple_pkg::VAL_W-1:0] ent;
  logic [NG*G-1:0][ple_pkg::VAL_W-1:0]     val_pad;
  logic [NG*G-1:0]                         hit_c, hit_q;

  logic          v1_q, v2_q, ov_q;
  logic [1:0]    op1_q, op2_q, st1_q, st2_q, st_d;
  logic [CW-1:0] cnt1_q, cnt2_q;
  logic [1:0]    st_pre;

  logic [NG-1:0]                      g_any;
  logic [NG-1:0][GW-1:0]              g_loc;
  logic [NG-1:0][ple_pkg::VAL_W-1:0]  g_val;

  logic                      found;
  logic [NGW-1:0]            g_sel;
  logic [GW-1:0]             l_sel;
  logic [ple_pkg::VAL_W-1:0] v_sel;
  logic [MW-1:0]             match_w;
  logic [WW-1:0]             len_w;
  logic                      load_out;
  ple_pkg::out_t             out_q, out_d;

  assign in_stall_o = v1_q | v2_q;
  assign acc        = in_valid_i & ~in_stall_o;

  assign pos_w  = {{CW{1'b0}}, in_data_i.position};
  assign cnt_w  = {8'd0, cnt_q};
  assign full   = (cnt_q >= CW'(CAPACITY));
  assign ins_ok = ~full && (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
  assign pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign idx    = IW'(pos_w - WW'(1));

  always_comb begin
    ctrl.ins = acc && (in_data_i.operation == ple_pkg::OP_INSERT) && ins_ok;
    ctrl.del = acc && (in_data_i.operation == ple_pkg::OP_DELETE) && pos_ok;
    ctrl.find = acc && (in_data_i.operation == ple_pkg::OP_FIND);
    ctrl.rd  = acc && (in_data_i.operation == ple_pkg::OP_READ) && pos_ok;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl.del) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_comb begin
    case (in_data_i.operation)
      ple_pkg::OP_INSERT: st_pre = full ? ple_pkg::ST_FULL :
                                   (ins_ok ? ple_pkg::ST_DONE : ple_pkg::ST_BAD_POS);
      ple_pkg::OP_DELETE: st_pre = pos_ok ? ple_pkg::ST_DONE : ple_pkg::ST_BAD_POS;
      ple_pkg::OP_READ:   st_pre = pos_ok ? ple_pkg::ST_DONE : ple_pkg::ST_BAD_POS;
      default:            st_pre = ple_pkg::ST_NOT_FOUND;
    endcase
  end

  for (genvar i = 0; i < NG * G; i++) begin : g_cells
    if (i < CAPACITY) begin : g_real
      ple_cell #(.IDX(i), .IW(IW), .CW(CW)) u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .idx_i  (idx),
        .cnt_i  (cnt_q),
        .value_i(in_data_i.value),
        .prev_i (ent[(i == 0) ? 0 : i - 1]),
        .next_i (ent[(i == CAPACITY - 1) ? i : i + 1]),
        .ent_o  (ent[i]),
        .hit_o  (hit_c[i])
      );
      assign val_pad[i] = ent[i];
    end else begin : g_pad
      assign hit_c[i]   = 1'b0;
      assign val_pad[i] = '0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_groups
    ple_group u_group (
      .clk_i(clk_i),
      .en_i (v1_q),
      .hit_i(hit_q[g*G +: G]),
      .val_i(val_pad[g*G +: G]),
      .any_o(g_any[g]),
      .loc_o(g_loc[g]),
      .val_o(g_val[g])
    );
  end

  always_comb begin
    found = 1'b0;
    g_sel = '0;
    l_sel = '0;
    v_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        found = 1'b1;
        g_sel = NGW'(g);
        l_sel = g_loc[g];
        v_sel = g_val[g];
      end
    end
  end

  assign match_w  = {8'd0, g_sel, l_sel} + MW'(1);
  assign len_w    = {8'd0, cnt2_q};
  assign load_out = v2_q && (~ov_q || ~out_stall_i);

  always_comb begin
    st_d = st2_q;
    if (op2_q == ple_pkg::OP_FIND) begin
      st_d = found ? ple_pkg::ST_DONE : ple_pkg::ST_NOT_FOUND;
    end
    out_d.status         = st_d;
    out_d.match_position = (op2_q == ple_pkg::OP_FIND && found) ? match_w[7:0] : 8'd0;
    out_d.read_value     = (op2_q == ple_pkg::OP_READ && st2_q == ple_pkg::ST_DONE) ?
                           v_sel : '0;
    out_d.list_length    = len_w[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= acc;
      if (v1_q) begin
        v2_q <= 1'b1;
      end else if (load_out) begin
        v2_q <= 1'b0;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (~out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      hit_q  <= hit_c;
      op1_q  <= in_data_i.operation;
      st1_q  <= st_pre;
      cnt1_q <= cnt_d;
    end
    if (v1_q) begin
      op2_q  <= op1_q;
      st2_q  <= st1_q;
      cnt2_q <= cnt1_q;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v1_q && v2_q))
    else $error("two requests in the select path");

  a_accept_to_v1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q)
    else $error("accepted beat did not enter the select path");

  a_read_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && op1_q == ple_pkg::OP_READ) |-> $onehot0(hit_q))
    else $error("read hit more than one cell");

  a_v2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !ov_q) |=> ov_q)
    else $error("result did not reach the output register");
`endif

endmodule

@@ tb/sv/tb_positional_list_engine_top.sv @@
// Testbench for positional_list_engine_top: a mirror of the list predicts every
// result beat, which is then checked field by field. Random ops under stalls.
// Depends on ple_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

import ple_pkg::*;

class list_mirror;
  logic signed [VAL_W-1:0] cells [CAPACITY_DEF];
  int unsigned             fill;
  out_t                    replies [$];
  int unsigned             errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function int unsigned pending();
    return replies.size();
  endfunction

  function void take_request(in_t rq);
    out_t        r;
    int unsigned p;
    int unsigned k;
    r = '0;
    r.status = ST_DONE;
    p = rq.position;
    case (rq.operation)
      OP_INSERT: begin
        if (fill >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > fill + 1) begin
          r.status = ST_BAD_POS;
        end else begin
          for (k = fill; k >= p; k--) cells[k] = cells[k - 1];
          cells[p - 1] = rq.value;
          fill++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > fill) begin
          r.status = ST_BAD_POS;
        end else begin
          for (k = p; k < fill; k++) cells[k - 1] = cells[k];
          fill--;
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (k = 0; k < fill && r.status == ST_NOT_FOUND; k++) begin
          if (cells[k] == rq.value) begin
            r.status         = ST_DONE;
            r.match_position = 8'(k + 1);
          end
        end
      end
      OP_READ: begin
        if (p < 1 || p > fill) r.status = ST_BAD_POS;
        else r.read_value = cells[p - 1];
      end
    endcase
    r.list_length = 8'(fill);
    replies.push_back(r);
  endfunction

  function void report(string what, logic signed [63:0] want_v, logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  function void match_result(out_t got);
    out_t want;
    if (replies.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = replies.pop_front();
    report("status", want.status, got.status);
    report("match_position", want.match_position, got.match_position);
    report("read_value", want.read_value, got.read_value);
    report("list_length", want.list_length, got.list_length);
  endfunction
endclass

module tb_positional_list_engine_top;

  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned PHASE_BEATS = 584;
  localparam int unsigned TIDE_BEATS  = 250;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  list_mirror  sb;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left   = 0;
  int unsigned cycles      = 0;

  positional_list_engine_top #(
    .CAPACITY(CAPACITY_DEF)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check the beat taken at this edge, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.match_result(out_data_o);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_t req(logic [1:0] op, logic [7:0] pos, logic signed [VAL_W-1:0] val);
    in_t it;
    it.operation = op;
    it.position  = pos;
    it.value     = val;
    return it;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0, 1, 2: return $urandom;
      3, 4:    return 32'($urandom_range(15)) - 32'd8;
      5:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(255));
    endcase
  endfunction

  function automatic in_t make_item(bit growing);
    in_t         it;
    int unsigned roll;
    int unsigned n;
    n    = sb.fill;
    roll = $urandom_range(99);
    if (growing) begin
      it.operation = roll < 70 ? OP_INSERT : roll < 80 ? OP_DELETE :
                     roll < 90 ? OP_FIND : OP_READ;
    end else begin
      it.operation = roll < 10 ? OP_INSERT : roll < 70 ? OP_DELETE :
                     roll < 85 ? OP_FIND : OP_READ;
    end
    it.value = pick_value();
    if (it.operation == OP_FIND && n > 0 && $urandom_range(1))
      it.value = sb.cells[$urandom_range(n - 1)];
    if ($urandom_range(9) == 0) begin
      it.position = 8'($urandom_range(255));
    end else if (it.operation == OP_INSERT) begin
      it.position = 8'($urandom_range(n + 1, 1));
    end else begin
      it.position = (n == 0) ? 8'd1 : 8'($urandom_range(n, 1));
    end
    return it;
  endfunction

  task automatic send_beat(in_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_request(item);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned beat_idx;
    int unsigned ph;
    int unsigned i;
    sb = new();
    beat_idx = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 30;
    rx_idle_pct = 81;
    // empty list, bounds, extreme values, duplicates
    send_beat(req(OP_READ,   8'd1,   32'sd0));
    send_beat(req(OP_DELETE, 8'd1,   32'sd0));
    send_beat(req(OP_FIND,   8'd0,   32'sd0));
    send_beat(req(OP_INSERT, 8'd0,   32'sd7));
    send_beat(req(OP_INSERT, 8'd2,   32'sd7));
    send_beat(req(OP_INSERT, 8'd1,   32'h7fff_ffff));
    send_beat(req(OP_INSERT, 8'd1,   32'h8000_0000));
    send_beat(req(OP_INSERT, 8'd3,   32'sd0));
    send_beat(req(OP_INSERT, 8'd2,   -32'sd1));
    send_beat(req(OP_INSERT, 8'd5,   -32'sd1));
    send_beat(req(OP_INSERT, 8'd255, 32'sd5));
    send_beat(req(OP_FIND,   8'd0,   -32'sd1));
    send_beat(req(OP_FIND,   8'd0,   32'h8000_0000));
    send_beat(req(OP_FIND,   8'd0,   32'sd12345));
    send_beat(req(OP_READ,   8'd0,   32'sd0));
    send_beat(req(OP_READ,   8'd6,   32'sd0));
    send_beat(req(OP_READ,   8'd5,   32'sd0));
    send_beat(req(OP_READ,   8'd1,   32'sd0));
    send_beat(req(OP_READ,   8'd255, 32'sd0));
    send_beat(req(OP_DELETE, 8'd6,   32'sd0));
    send_beat(req(OP_DELETE, 8'd0,   32'sd0));
    send_beat(req(OP_DELETE, 8'd1,   32'sd0));
    send_beat(req(OP_DELETE, 8'd4,   32'sd0));
    send_beat(req(OP_READ,   8'd3,   32'sd0));
    send_beat(req(OP_FIND,   8'd0,   32'h7fff_ffff));
    drain();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_left   = 90;
        end
      endcase
      for (i = 0; i < PHASE_BEATS; i++) begin
        send_beat(make_item(((beat_idx / TIDE_BEATS) % 2) == 0));
        beat_idx++;
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ positional_list_engine_top.f @@
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_group.sv
rtl/positional_list_engine_top.sv
tb/sv/tb_positional_list_engine_top.sv
